// ===== design/lfrs_pkg.sv =====
// Package for the fractional row shifter: field widths, mode and register
// codes, and small helper functions. No dependencies.
`default_nettype none

package lfrs_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int WBITS       = 24;
    localparam int MAX_ROW     = 1024;
    localparam int ADDR_W      = 10;
    localparam int LEN_W       = 11;
    localparam int SHIFT_W     = 28;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 2;

    // Datapath widths
    localparam int ACC_W   = 36;   // weight accumulator, Q24
    localparam int XK_W    = 20;   // x - k, Q16 signed
    localparam int PROD_W  = ACC_W + XK_W;
    localparam int WGT_W   = 28;   // finished weight, Q24 signed
    localparam int SUM_W   = 48;   // tap accumulator
    localparam int NUM_W   = ACC_W + 1;
    localparam int DEN_W   = 13;   // up to 7! = 5040

    // Two-step thresholds, in percent of one sample
    localparam int TWO_LO_PCT = 30;
    localparam int TWO_HI_PCT = 70;

    // Interpolation modes
    localparam logic [MODE_W-1:0] MODE_NEAREST  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CUBIC    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUINTIC  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HEPTIC   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TWO_STEP = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd2;

    // Factorials 0! .. 7!
    function automatic logic [DEN_W-1:0] fact(input logic [2:0] v);
        logic [DEN_W-1:0] r;
        unique case (v)
            3'd0:    r = 13'd1;
            3'd1:    r = 13'd1;
            3'd2:    r = 13'd2;
            3'd3:    r = 13'd6;
            3'd4:    r = 13'd24;
            3'd5:    r = 13'd120;
            3'd6:    r = 13'd720;
            default: r = 13'd5040;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/lfrs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lfrs_pkg for widths.
`default_nettype none

module lfrs_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [lfrs_pkg::NUM_W-1:0]    num,
    input  wire logic [lfrs_pkg::DEN_W-1:0]    den,
    output logic                               done,
    output logic [lfrs_pkg::NUM_W-1:0]         quot
);

    localparam int CNT_W = $clog2(lfrs_pkg::NUM_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [lfrs_pkg::NUM_W-1:0]    dvd_reg, dvd_next;
    logic [lfrs_pkg::DEN_W-1:0]    rem_reg, rem_next;
    logic [lfrs_pkg::DEN_W-1:0]    den_reg, den_next;
    logic [lfrs_pkg::DEN_W:0]      rem_sh;
    logic                          ge;

    // Trial subtraction
    assign rem_sh = {rem_reg, dvd_reg[lfrs_pkg::NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? lfrs_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[lfrs_pkg::DEN_W-1:0];
            dvd_next = {dvd_reg[lfrs_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(lfrs_pkg::NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

`default_nettype wire

// ===== design/lagrange_fractional_row_shift.sv =====
// Fractional row shifter, top level: row buffer, sequencer, shared multiplier.
// Depends on lfrs_pkg and lfrs_div.
//
// Usage:
//   Input stream (s_*): s_tuser is the command (0 load, 1 read), s_tdata
//   carries the sample index and the sample value. A load transfer writes
//   one buffer entry. A read transfer produces one result on the output
//   stream (m_*): the shifted sample and a flag in m_tuser that tells
//   whether it was clipped.
//   Configuration (mode, shift, row length) is written on the cfg_* port;
//   the user must write it only while the block is idle, which the block
//   does not enforce. A read issues one buffer read per tap through the
//   single memory port into the multiply/accumulate pipeline: two taps for
//   nearest and two-step, 2*m taps for a polynomial mode. The first
//   polynomial read after a mode or shift write also computes the weights
//   on the shared multiplier and divider.
//   The block takes one item at a time; s_tready is high only when idle.
//   A result waits in the output register while m_tready is low; a new item
//   may be accepted then, and its result waits until the register frees.
//   Reset restores the register defaults and marks the weights stale; the
//   buffer contents are not cleared.
`default_nettype none

module lagrange_fractional_row_shift (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [31:0]                          s_tdata,  // sample_index[9:0], sample_value[25:10]
    input  wire logic                                 s_tuser,  // cmd
    // Result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [15:0]                               m_tdata,  // shifted_value[15:0]
    output logic                                      m_tuser,  // saturated
    // Configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [lfrs_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [lfrs_pkg::SHIFT_W-1:0]         cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WMUL   = 7'b0000010,
        ST_WRND   = 7'b0000100,
        ST_WDST   = 7'b0001000,
        ST_WDIV   = 7'b0010000,
        ST_TAPS   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    localparam int SB = lfrs_pkg::SAMPLE_BITS;
    localparam logic signed [lfrs_pkg::SHIFT_W-1:0] SH_LIM =
        lfrs_pkg::SHIFT_W'(lfrs_pkg::MAX_ROW) <<< lfrs_pkg::FRAC_BITS;
    localparam logic signed [lfrs_pkg::ACC_W-1:0] ACC_ONE =
        lfrs_pkg::ACC_W'(1) <<< lfrs_pkg::WBITS;

    // Round to nearest, halves away from zero, for the weight product
    function automatic logic signed [lfrs_pkg::ACC_W-1:0] rnd_prod(
        input logic signed [lfrs_pkg::PROD_W-1:0] p);
        logic [lfrs_pkg::PROD_W-1:0] mag;
        logic [lfrs_pkg::PROD_W-1:0] r;
        logic [lfrs_pkg::ACC_W-1:0]  rq;
        mag = p[lfrs_pkg::PROD_W-1] ? lfrs_pkg::PROD_W'(-p) : lfrs_pkg::PROD_W'(p);
        r   = (mag + (lfrs_pkg::PROD_W'(1) << (lfrs_pkg::FRAC_BITS - 1)))
              >> lfrs_pkg::FRAC_BITS;
        rq  = r[lfrs_pkg::ACC_W-1:0];
        return p[lfrs_pkg::PROD_W-1] ? -$signed(rq) : $signed(rq);
    endfunction

    // Same rounding for the tap sum
    function automatic logic signed [lfrs_pkg::SUM_W-1:0] rnd_sum(
        input logic signed [lfrs_pkg::SUM_W-1:0] s);
        logic [lfrs_pkg::SUM_W-1:0] mag;
        logic [lfrs_pkg::SUM_W-1:0] r;
        mag = s[lfrs_pkg::SUM_W-1] ? lfrs_pkg::SUM_W'(-s) : lfrs_pkg::SUM_W'(s);
        r   = (mag + (lfrs_pkg::SUM_W'(1) << (lfrs_pkg::WBITS - 1))) >> lfrs_pkg::WBITS;
        return s[lfrs_pkg::SUM_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // Configuration registers
    logic [lfrs_pkg::MODE_W-1:0]          mode_reg;
    logic signed [lfrs_pkg::SHIFT_W-1:0]  shift_reg;
    logic [lfrs_pkg::LEN_W-1:0]           len_reg;
    logic                                 dirty_reg;

    // Sequencer and datapath registers
    state_t                               state_reg, state_next;
    logic [lfrs_pkg::ADDR_W-1:0]          idx_reg;
    logic                                 zero_reg;
    logic [3:0]                           c_reg;
    logic [2:0]                           t_reg;
    logic [2:0]                           kc_reg;
    logic signed [lfrs_pkg::ACC_W-1:0]    acc_reg;
    logic signed [lfrs_pkg::PROD_W-1:0]   prod_reg;
    logic signed [lfrs_pkg::SUM_W-1:0]    sum_reg;
    logic signed [lfrs_pkg::WGT_W-1:0]    wgt_reg [8];
    logic                                 tv_d1_reg, pv_d2_reg, inrow_d1_reg;
    logic [2:0]                           tidx_d1_reg;
    logic signed [SB-1:0]                 tapa_reg, tapb_reg;
    logic signed [SB-1:0]                 mem_q_reg;
    logic                                 m_valid_reg;
    logic [SB-1:0]                        m_data_reg;
    logic                                 m_sat_reg;

    logic signed [SB-1:0]                 row_mem [lfrs_pkg::MAX_ROW];

    // Shift split into floor and fraction
    logic signed [lfrs_pkg::SHIFT_W-1:0]  sh_cl, af;
    logic signed [12:0]                   ia;
    logic [lfrs_pkg::FRAC_BITS-1:0]       frac;
    logic [lfrs_pkg::LEN_W-1:0]           n_lim;
    logic signed [12:0]                   n_s;
    logic                                 zero_cond;

    always_comb begin
        priority if (shift_reg > SH_LIM)  sh_cl = SH_LIM;
        else if (shift_reg < -SH_LIM)     sh_cl = -SH_LIM;
        else                              sh_cl = shift_reg;
        af    = -sh_cl;
        ia    = 13'(af >>> lfrs_pkg::FRAC_BITS);
        frac  = af[lfrs_pkg::FRAC_BITS-1:0];
        n_lim = (len_reg > lfrs_pkg::LEN_W'(lfrs_pkg::MAX_ROW))
                ? lfrs_pkg::LEN_W'(lfrs_pkg::MAX_ROW) : len_reg;
        n_s   = $signed({2'b00, n_lim});
    end

    // Input item fields
    logic [lfrs_pkg::ADDR_W-1:0]  in_idx;
    logic signed [SB-1:0]         in_val;
    logic                         s_acc;
    assign in_idx = s_tdata[9:0];
    assign in_val = s_tdata[25:10];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign zero_cond = (ia <= -n_s) || (ia >= n_s) ||
                       ({1'b0, in_idx} >= n_lim) || (mode_reg > lfrs_pkg::MODE_TWO_STEP);

    // Taps per item: nearest and two-step read nodes 0 and 1
    logic       poly;
    logic [2:0] m_eff;
    logic [3:0] taps;
    assign poly  = (mode_reg >= lfrs_pkg::MODE_LINEAR) && (mode_reg <= lfrs_pkg::MODE_HEPTIC);
    assign m_eff = poly ? mode_reg : 3'd1;
    assign taps  = {m_eff, 1'b0};

    // Tap position for the current issue slot
    logic signed [3:0]  j_s;
    logic signed [13:0] pos;
    logic               inrow, issue;
    assign j_s   = $signed({1'b0, c_reg[2:0]}) + 4'sd1 - $signed({1'b0, m_eff});
    assign pos   = 14'($signed({4'b0000, idx_reg})) + 14'(ia) + 14'(j_s);
    assign inrow = !pos[13] && (pos < 14'($signed({3'b000, n_lim})));
    assign issue = (state_reg == ST_TAPS) && (c_reg < taps);

    // Weight node offset x - k
    logic signed [3:0]                   k_s;
    logic signed [lfrs_pkg::XK_W-1:0]    xk;
    assign k_s = $signed({1'b0, kc_reg}) + 4'sd1 - $signed({1'b0, mode_reg});
    assign xk  = $signed({4'b0000, frac}) - $signed({k_s, 16'h0000});

    // Shared multiplier operands
    logic signed [SB-1:0]                tap_s;
    logic signed [lfrs_pkg::ACC_W-1:0]   mul_a;
    logic signed [lfrs_pkg::XK_W-1:0]    mul_b;
    assign tap_s = inrow_d1_reg ? mem_q_reg : '0;
    always_comb begin
        if (state_reg == ST_TAPS) begin
            mul_a = lfrs_pkg::ACC_W'(wgt_reg[tidx_d1_reg]);
            mul_b = lfrs_pkg::XK_W'(tap_s);
        end else begin
            mul_a = acc_reg;
            mul_b = xk;
        end
    end

    // Next weight-node counter, skipping the node of the weight itself
    logic [3:0] kc_inc, kc_nxt;
    assign kc_inc = {1'b0, kc_reg} + 4'd1;
    assign kc_nxt = (kc_inc == {1'b0, t_reg}) ? kc_inc + 4'd1 : kc_inc;

    // Divider hookup: rounded division of |acc| by the node product
    logic [lfrs_pkg::DEN_W-1:0]  den_mag;
    logic [2:0]                  t_rev;
    logic [lfrs_pkg::NUM_W-1:0]  div_num, div_q;
    logic [lfrs_pkg::ACC_W-1:0]  acc_mag;
    logic                        div_start, div_done, w_neg;
    logic [lfrs_pkg::WGT_W-1:0]  wq;
    assign t_rev    = 3'({mode_reg, 1'b0} - 4'd1 - {1'b0, t_reg});
    assign den_mag  = lfrs_pkg::DEN_W'(lfrs_pkg::fact(t_reg) * lfrs_pkg::fact(t_rev));
    assign acc_mag  = acc_reg[lfrs_pkg::ACC_W-1] ? lfrs_pkg::ACC_W'(-acc_reg)
                                                 : lfrs_pkg::ACC_W'(acc_reg);
    assign div_num  = {1'b0, acc_mag} + lfrs_pkg::NUM_W'(den_mag >> 1);
    assign div_start = (state_reg == ST_WDST);
    assign w_neg    = acc_reg[lfrs_pkg::ACC_W-1] ^ t_rev[0];
    assign wq       = div_q[lfrs_pkg::WGT_W-1:0];

    lfrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_mag),
        .done    (div_done),
        .quot    (div_q)
    );

    // Result selection
    logic signed [lfrs_pkg::SUM_W-1:0] rsum;
    logic signed [SB:0]                ab, ab_avg;
    logic [SB:0]                       ab_mag, ab_half;
    logic [23:0]                       frac100;
    logic [SB-1:0]                     res_val;
    logic                              res_sat;
    always_comb begin
        rsum    = rnd_sum(sum_reg);
        ab      = (SB+1)'(tapa_reg) + (SB+1)'(tapb_reg);
        ab_mag  = ab[SB] ? (SB+1)'(-ab) : (SB+1)'(ab);
        ab_half = (ab_mag + 1'b1) >> 1;
        ab_avg  = ab[SB] ? -$signed(ab_half) : $signed(ab_half);
        frac100 = 24'(frac) * 24'd100;
        res_sat = 1'b0;
        res_val = '0;
        if (zero_reg) begin
            res_val = '0;
        end else if (mode_reg == lfrs_pkg::MODE_NEAREST) begin
            res_val = tapa_reg;
        end else if (mode_reg == lfrs_pkg::MODE_TWO_STEP) begin
            priority if (frac100 < (24'(lfrs_pkg::TWO_LO_PCT) << lfrs_pkg::FRAC_BITS))
                res_val = tapa_reg;
            else if (frac100 > (24'(lfrs_pkg::TWO_HI_PCT) << lfrs_pkg::FRAC_BITS))
                res_val = tapb_reg;
            else
                res_val = ab_avg[SB-1:0];
        end else begin
            priority if (rsum > lfrs_pkg::SUM_W'((1 << (SB - 1)) - 1)) begin
                res_val = {1'b0, {(SB-1){1'b1}}};
                res_sat = 1'b1;
            end else if (rsum < -lfrs_pkg::SUM_W'(1 << (SB - 1))) begin
                res_val = {1'b1, {(SB-1){1'b0}}};
                res_sat = 1'b1;
            end else begin
                res_val = rsum[SB-1:0];
            end
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser) begin
                    priority if (zero_cond)      state_next = ST_FIN;
                    else if (poly && dirty_reg)  state_next = ST_WMUL;
                    else                         state_next = ST_TAPS;
                end
            end
            ST_WMUL: state_next = ST_WRND;
            ST_WRND: state_next = (kc_nxt >= {mode_reg, 1'b0}) ? ST_WDST : ST_WMUL;
            ST_WDST: state_next = ST_WDIV;
            ST_WDIV: begin
                if (div_done)
                    state_next = ({1'b0, t_reg} == {mode_reg, 1'b0} - 4'd1) ? ST_TAPS : ST_WMUL;
            end
            ST_TAPS: if (c_reg == taps + 4'd1) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= lfrs_pkg::MODE_HEPTIC;
            shift_reg   <= '0;
            len_reg     <= lfrs_pkg::LEN_W'(lfrs_pkg::MAX_ROW);
            dirty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
            tv_d1_reg   <= 1'b0;
            pv_d2_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            tv_d1_reg <= issue;
            pv_d2_reg <= tv_d1_reg;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    lfrs_pkg::REG_INTERP_MODE: begin
                        mode_reg  <= cfg_wdata[lfrs_pkg::MODE_W-1:0];
                        dirty_reg <= 1'b1;
                    end
                    lfrs_pkg::REG_SHIFT_AMOUNT: begin
                        shift_reg <= $signed(cfg_wdata);
                        dirty_reg <= 1'b1;
                    end
                    lfrs_pkg::REG_ROW_LENGTH: len_reg <= cfg_wdata[lfrs_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_WDIV && div_done && state_next == ST_TAPS)
                dirty_reg <= 1'b0;
            if (state_reg == ST_FIN && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        prod_reg     <= mul_a * mul_b;
        inrow_d1_reg <= inrow;
        tidx_d1_reg  <= c_reg[2:0];
        if (s_acc && s_tuser) begin
            idx_reg  <= in_idx;
            zero_reg <= zero_cond;
            c_reg    <= '0;
            sum_reg  <= '0;
            t_reg    <= '0;
            kc_reg   <= 3'd1;
            acc_reg  <= ACC_ONE;
        end
        if (state_reg == ST_WRND) begin
            acc_reg <= rnd_prod(prod_reg);
            kc_reg  <= kc_nxt[2:0];
        end
        if (state_reg == ST_WDIV && div_done) begin
            wgt_reg[t_reg] <= w_neg ? -$signed(wq) : $signed(wq);
            t_reg   <= t_reg + 3'd1;
            kc_reg  <= (t_reg == 3'd7) ? 3'd0 : ((t_reg + 3'd1 == 3'd0) ? 3'd1 : 3'd0);
            acc_reg <= ACC_ONE;
        end
        if (state_reg == ST_TAPS) begin
            c_reg <= c_reg + 4'd1;
            if (tv_d1_reg) begin
                if (tidx_d1_reg == 3'd0) tapa_reg <= tap_s;
                if (tidx_d1_reg == 3'd1) tapb_reg <= tap_s;
            end
            if (pv_d2_reg)
                sum_reg <= sum_reg + prod_reg[lfrs_pkg::SUM_W-1:0];
        end
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg <= res_val;
            m_sat_reg  <= res_sat;
        end
    end

    // Row buffer: one port, loads in idle, tap reads while shifting
    always_ff @(posedge aclk) begin
        if (s_acc && !s_tuser)
            row_mem[in_idx] <= in_val;
        if (issue)
            mem_q_reg <= row_mem[pos[lfrs_pkg::ADDR_W-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule

`default_nettype wire
